FILE: rtl/nlc_pkg.sv
// Shared types and character constants for the numeric literal classifier.
package nlc_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ONE   = 8'h31;
	localparam logic [7:0] CHAR_SEVEN = 8'h37;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;
	localparam logic [7:0] CHAR_LOW_B = 8'h62;
	localparam logic [7:0] CHAR_LOW_E = 8'h65;
	localparam logic [7:0] CHAR_LOW_F = 8'h66;
	localparam logic [7:0] CHAR_LOW_X = 8'h78;
	localparam logic [7:0] CHAR_DOT   = 8'h2e;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;

	// Dot and exponent counters stop at this value.
	localparam logic [1:0] COUNT_SAT = 2'd2;
	localparam logic [1:0] POS_SAT   = 2'd3;

	typedef enum logic [2:0] {
		CLASS_FALSE  = 3'd0,
		CLASS_HEX    = 3'd1,
		CLASS_OCTAL  = 3'd2,
		CLASS_BINARY = 3'd3,
		CLASS_INT    = 3'd4,
		CLASS_FLOAT  = 3'd5
	} token_class_t;

	// Verdicts of one finished token, handed from the scanner to the back end.
	typedef struct packed {
		logic short_token;
		logic hex_ok;
		logic octal_ok;
		logic binary_ok;
		logic int_ok;
		logic float_ok;
	} verdict_t;

endpackage

FILE: rtl/nlc_front.sv
// Character scanner: keeps the running validator flags and emits verdicts per token.
module nlc_front
	import nlc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_code,
	input  logic       last,
	input  logic       accept,
	output logic       verdict_valid,
	output verdict_t   verdict
);

	logic [1:0] pos_q;
	logic       minus_q;
	logic       hex_q, octal_q, binary_q, int_q, float_q;
	logic [1:0] dot_q, exp_q;

	logic       strip;
	logic [1:0] eff;
	logic       is_dec, is_hex, is_oct;
	logic       hex_n, octal_n, binary_n, int_n, float_n, minus_n;
	logic [1:0] dot_n, exp_n;
	logic       prev_n;

	always_comb begin
		is_dec   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
		is_oct   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_SEVEN);
		is_hex   = is_dec || ((char_code >= CHAR_LOW_A) && (char_code <= CHAR_LOW_F));
		strip    = (pos_q == 2'd0) && (char_code == CHAR_MINUS);
		eff      = pos_q - {1'b0, minus_q};
		minus_n  = minus_q | strip;
		hex_n    = hex_q;
		octal_n  = octal_q;
		binary_n = binary_q;
		int_n    = int_q;
		float_n  = float_q;
		dot_n    = dot_q;
		exp_n    = exp_q;

		if (!strip) begin
			case (eff)
				2'd0: begin
					if (char_code != CHAR_ZERO) begin
						hex_n    = 1'b0;
						octal_n  = 1'b0;
						binary_n = 1'b0;
					end
				end
				2'd1: begin
					if (char_code != CHAR_LOW_X) hex_n = 1'b0;
					if (char_code != CHAR_LOW_B) binary_n = 1'b0;
					if (!is_oct) octal_n = 1'b0;
				end
				default: begin
					if (!is_hex) hex_n = 1'b0;
					if ((char_code != CHAR_ZERO) && (char_code != CHAR_ONE)) binary_n = 1'b0;
					if (!is_oct) octal_n = 1'b0;
				end
			endcase
			if (!is_dec) int_n = 1'b0;
		end

		// The float check sees every character, a leading minus included.
		if (char_code == CHAR_DOT) begin
			dot_n = (dot_q == COUNT_SAT) ? COUNT_SAT : dot_q + 2'd1;
		end else if (char_code == CHAR_LOW_E) begin
			exp_n = (exp_q == COUNT_SAT) ? COUNT_SAT : exp_q + 2'd1;
		end else if (!is_dec && (char_code != CHAR_MINUS)) begin
			float_n = 1'b0;
		end
		prev_n = (char_code == CHAR_LOW_E);

		verdict.short_token = (pos_q == 2'd0);
		verdict.hex_ok      = hex_n && !strip && (eff != 2'd0);
		verdict.octal_ok    = octal_n && !strip;
		verdict.binary_ok   = binary_n && !strip && (eff != 2'd0);
		verdict.int_ok      = int_n;
		verdict.float_ok    = float_n && (dot_n <= 2'd1) && (exp_n <= 2'd1) &&
		                      ((dot_n != 2'd0) || (exp_n != 2'd0)) && !prev_n;
		verdict_valid       = accept && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 2'd0;
			minus_q  <= 1'b0;
			hex_q    <= 1'b1;
			octal_q  <= 1'b1;
			binary_q <= 1'b1;
			int_q    <= 1'b1;
			float_q  <= 1'b1;
			dot_q    <= 2'd0;
			exp_q    <= 2'd0;
		end else if (accept) begin
			if (last) begin
				pos_q    <= 2'd0;
				minus_q  <= 1'b0;
				hex_q    <= 1'b1;
				octal_q  <= 1'b1;
				binary_q <= 1'b1;
				int_q    <= 1'b1;
				float_q  <= 1'b1;
				dot_q    <= 2'd0;
				exp_q    <= 2'd0;
			end else begin
				pos_q    <= (pos_q == POS_SAT) ? POS_SAT : pos_q + 2'd1;
				minus_q  <= minus_n;
				hex_q    <= hex_n;
				octal_q  <= octal_n;
				binary_q <= binary_n;
				int_q    <= int_n;
				float_q  <= float_n;
				dot_q    <= dot_n;
				exp_q    <= exp_n;
			end
		end
	end

endmodule

FILE: rtl/nlc_queue.sv
// Short flop queue of token verdicts between the scanner and the back end.
module nlc_queue
	import nlc_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	input  verdict_t push_data,
	output logic     full,
	input  logic     pop_req,
	output verdict_t pop_data,
	output logic     empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	verdict_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign do_push  = push_valid && !full;
	assign do_pop   = pop_req && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: rtl/nlc_back.sv
// Back end: resolves the token class and holds the result item for the consumer.
module nlc_back
	import nlc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_empty,
	input  verdict_t     q_data,
	output logic         q_pop,
	input  logic         pop,
	output logic         empty,
	output token_class_t token_class,
	output verdict_t     result
);

	logic         valid_q;
	token_class_t class_q;
	verdict_t     result_q;
	token_class_t class_d;

	always_comb begin
		if (q_data.short_token) class_d = CLASS_FALSE;
		else if (q_data.hex_ok) class_d = CLASS_HEX;
		else if (q_data.octal_ok) class_d = CLASS_OCTAL;
		else if (q_data.binary_ok) class_d = CLASS_BINARY;
		else if (q_data.int_ok) class_d = CLASS_INT;
		else if (q_data.float_ok) class_d = CLASS_FLOAT;
		else class_d = CLASS_FALSE;
	end

	assign q_pop       = !q_empty && (!valid_q || pop);
	assign empty       = !valid_q;
	assign token_class = class_q;
	assign result      = result_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			class_q  <= class_d;
			result_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/numeric_literal_classifier_unit.sv
// Numeric literal classifier: scanner, verdict queue and result stage.
// Throughput: one character per cycle while the queue is not full; the scanner flags are registered.
// Path: a token's verdict enters the queue when its last character is accepted and
// moves on to the result register once that register is empty or being popped.
// Reset: arst_n resets the scanner flags, empties the queue and drops the result.
// The queue depth sets how many finished tokens can wait before full is raised.
module numeric_literal_classifier_unit
	import nlc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_code,
	input  logic       last,
	input  logic       push,
	output logic       full,
	output logic [2:0] token_class,
	output logic       hex_ok,
	output logic       octal_ok,
	output logic       binary_ok,
	output logic       int_ok,
	output logic       float_ok,
	output logic       empty,
	input  logic       pop
);

	// A pushed character is taken whenever the verdict queue has room, so the scanner
	// never has to hold a finished token itself.
	logic         accept;
	logic         v_valid;
	verdict_t     v_data;
	logic         q_full;
	logic         q_empty;
	logic         q_pop;
	verdict_t     q_data;
	token_class_t class_w;
	verdict_t     result_w;

	assign full   = q_full;
	assign accept = push && !q_full;

	nlc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_code     (char_code),
		.last          (last),
		.accept        (accept),
		.verdict_valid (v_valid),
		.verdict       (v_data)
	);

	nlc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (v_valid),
		.push_data  (v_data),
		.full       (q_full),
		.pop_req    (q_pop),
		.pop_data   (q_data),
		.empty      (q_empty)
	);

	// The result register refills from the queue in the same cycle that the
	// consumer takes the current item, so results can leave back to back.
	nlc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.token_class (class_w),
		.result      (result_w)
	);

	assign token_class = class_w;
	assign hex_ok      = result_w.hex_ok;
	assign octal_ok    = result_w.octal_ok;
	assign binary_ok   = result_w.binary_ok;
	assign int_ok      = result_w.int_ok;
	assign float_ok    = result_w.float_ok;

`ifndef SYNTHESIS
	// A hex class must come with a passing hex verdict.
	a_hex_class: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (class_w == CLASS_HEX)) |-> hex_ok)
		else $error("hex class without hex verdict");

	// After a finished token is accepted, the result ports must not be empty.
	a_token_out: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && last) |-> ##2 !empty)
		else $error("finished token did not reach the output");

	// The queue can only fill up behind an occupied result register.
	a_full_order: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full while result register is empty");
`endif

endmodule
